// ===== rtl/pdf_date_to_iso8601_macros.svh =====
// ----------------------------------------------------------------------------
// pdf date to iso-8601 assertion macros
// shared property wrappers, clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef PDF_DATE_TO_ISO8601_MACROS_SVH
`define PDF_DATE_TO_ISO8601_MACROS_SVH

// same-cycle implication
`define PD2ISO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PD2ISO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pd2iso_pkg.sv =====
// ----------------------------------------------------------------------------
// pd2iso_pkg
// types, character codes and slot table shared by the date converter
// ----------------------------------------------------------------------------
`default_nettype none

package pd2iso_pkg;

  localparam int unsigned ISO_MAX = 24;
  localparam int unsigned IN_MAX  = 23;
  localparam int unsigned LEN_W   = 5;

  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // input positions of the grammar
  localparam logic [LEN_W-1:0] POS_PREFIX  = 5'd0;
  localparam logic [LEN_W-1:0] POS_COLON   = 5'd1;
  localparam logic [LEN_W-1:0] POS_DIG_END = 5'd15;
  localparam logic [LEN_W-1:0] POS_TZ      = 5'd16;
  localparam logic [LEN_W-1:0] POS_OFS_H0  = 5'd17;
  localparam logic [LEN_W-1:0] POS_OFS_H1  = 5'd18;
  localparam logic [LEN_W-1:0] POS_OFS_Q0  = 5'd19;
  localparam logic [LEN_W-1:0] POS_OFS_M0  = 5'd20;
  localparam logic [LEN_W-1:0] POS_OFS_M1  = 5'd21;
  localparam logic [LEN_W-1:0] POS_OFS_Q1  = 5'd22;
  localparam logic [LEN_W-1:0] POS_LIMIT   = 5'd23;

  typedef enum logic [1:0] {
    TZ_NONE   = 2'd0,
    TZ_ZULU   = 2'd1,
    TZ_OFFSET = 2'd2
  } tz_e;

  typedef struct packed {
    logic                           ok;
    logic [LEN_W-1:0]               len;
    logic [ISO_MAX-1:0][7:0]        chars;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // output slot of the digit at input positions 2..15
  function automatic logic [LEN_W-1:0] digit_slot(input logic [3:0] p);
    logic [LEN_W-1:0] s;
    unique case (p)
      4'd3:    s = 5'd1;
      4'd4:    s = 5'd2;
      4'd5:    s = 5'd3;
      4'd6:    s = 5'd5;
      4'd7:    s = 5'd6;
      4'd8:    s = 5'd8;
      4'd9:    s = 5'd9;
      4'd10:   s = 5'd11;
      4'd11:   s = 5'd12;
      4'd12:   s = 5'd14;
      4'd13:   s = 5'd15;
      4'd14:   s = 5'd17;
      4'd15:   s = 5'd18;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pd2iso_front.sv =====
// ----------------------------------------------------------------------------
// pd2iso_front
// grammar check and iso text assembly, one byte per cycle unless queue full
// ----------------------------------------------------------------------------
`default_nettype none

module pd2iso_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_char_i,
  input  wire logic              in_last_i,
  input  wire pd2iso_pkg::q_status_t q_status_i,
  output logic                   push_o,
  output pd2iso_pkg::frame_t     frame_o
);
  import pd2iso_pkg::*;

  logic [LEN_W-1:0]        pos_q, pos_d;
  tz_e                     tz_q, tz_d;
  logic                    err_q, err_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [ISO_MAX-1:0][7:0] chars_q, chars_d;
  logic                    ok;
  logic                    is_dig;
  logic [LEN_W-1:0]        slot;
  logic [7:0]              sep;
  logic                    boundary;
  logic                    take;

  assign in_ready_o = !q_status_i.full;
  assign take       = in_valid_i && in_ready_o;
  assign is_dig     = (in_char_i >= CH_ZERO) && (in_char_i <= CH_NINE);
  assign slot       = digit_slot(pos_q[3:0]);
  assign sep        = (pos_q == 5'd10) ? CH_T : ((pos_q >= 5'd12) ? CH_COLON : CH_MINUS);

  always_comb begin
    pos_d   = pos_q;
    tz_d    = tz_q;
    err_d   = err_q;
    len_d   = len_q;
    chars_d = chars_q;
    ok      = 1'b0;
    if (pos_q >= POS_LIMIT) begin
      ok = 1'b0;
    end else if (pos_q == POS_PREFIX) begin
      ok = (in_char_i == CH_D);
    end else if (pos_q == POS_COLON) begin
      ok = (in_char_i == CH_COLON);
    end else if (pos_q <= POS_DIG_END) begin
      ok = is_dig;
      if (is_dig) begin
        if (pos_q >= 5'd6 && !pos_q[0]) begin
          chars_d[slot - 5'd1] = sep;
        end
        chars_d[slot] = in_char_i;
        if (pos_q >= 5'd5 && pos_q[0]) begin
          len_d = slot + 5'd1;
        end
      end
    end else if (pos_q == POS_TZ) begin
      if (in_char_i == CH_Z) begin
        ok          = 1'b1;
        chars_d[19] = in_char_i;
        tz_d        = TZ_ZULU;
        len_d       = 5'd20;
      end else if (in_char_i == CH_PLUS || in_char_i == CH_MINUS) begin
        ok          = 1'b1;
        chars_d[19] = in_char_i;
        tz_d        = TZ_OFFSET;
      end
    end else if (tz_q == TZ_OFFSET) begin
      case (pos_q)
        POS_OFS_H0: begin
          ok          = is_dig;
          chars_d[20] = in_char_i;
        end
        POS_OFS_H1: begin
          ok          = is_dig;
          chars_d[21] = in_char_i;
        end
        POS_OFS_Q0: begin
          ok    = (in_char_i == CH_QUOTE);
          len_d = 5'd22;
        end
        POS_OFS_M0: begin
          ok          = is_dig;
          chars_d[22] = in_char_i;
        end
        POS_OFS_M1: begin
          ok          = is_dig;
          chars_d[23] = in_char_i;
        end
        POS_OFS_Q1: begin
          ok    = (in_char_i == CH_QUOTE);
          len_d = 5'd24;
        end
        default: ok = 1'b0;
      endcase
    end
    // errors freeze everything until the final byte
    if (err_q) begin
      tz_d    = tz_q;
      len_d   = len_q;
      chars_d = chars_q;
    end else if (ok) begin
      pos_d = pos_q + 5'd1;
    end else begin
      tz_d    = tz_q;
      len_d   = len_q;
      chars_d = chars_q;
      err_d   = 1'b1;
    end
  end

  always_comb begin
    boundary = 1'b0;
    if (pos_d >= 5'd6 && pos_d <= 5'd16 && !pos_d[0]) begin
      boundary = 1'b1;
    end else if (pos_d == 5'd17 && tz_d == TZ_ZULU) begin
      boundary = 1'b1;
    end else if ((pos_d == 5'd20 || pos_d == 5'd23) && tz_d == TZ_OFFSET) begin
      boundary = 1'b1;
    end
  end

  assign push_o        = take && in_last_i;
  assign frame_o.ok    = !err_d && boundary && (len_d != '0);
  assign frame_o.len   = len_d;
  assign frame_o.chars = chars_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tz_q  <= TZ_NONE;
      err_q <= 1'b0;
      len_q <= '0;
    end else if (take) begin
      if (in_last_i) begin
        pos_q <= '0;
        tz_q  <= TZ_NONE;
        err_q <= 1'b0;
        len_q <= '0;
      end else begin
        pos_q <= pos_d;
        tz_q  <= tz_d;
        err_q <= err_d;
        len_q <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      chars_q <= chars_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pd2iso_queue.sv =====
// ----------------------------------------------------------------------------
// pd2iso_queue
// short queue of finished strings between the parser and the emitter
// ----------------------------------------------------------------------------
`default_nettype none

module pd2iso_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire pd2iso_pkg::frame_t    frame_i,
  input  wire logic                  pop_i,
  output pd2iso_pkg::frame_t         head_o,
  output pd2iso_pkg::q_status_t      status_o
);
  import pd2iso_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= frame_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pd2iso_back.sv =====
// ----------------------------------------------------------------------------
// pd2iso_back
// emitter walking a finished string out one character per cycle while ready
// ----------------------------------------------------------------------------
`default_nettype none

module pd2iso_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pd2iso_pkg::frame_t    head_i,
  input  wire pd2iso_pkg::q_status_t q_status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_char_o,
  output logic                       out_ok_o,
  output logic                       out_last_o
);
  import pd2iso_pkg::*;

  logic [LEN_W-1:0] idx_q, idx_d;
  logic             vld_q;
  logic [7:0]       char_q;
  logic             ok_q, last_q;
  logic             issue;
  logic             is_end;

  assign issue  = !q_status_i.empty && (!vld_q || out_ready_i);
  assign is_end = !head_i.ok || (idx_q == head_i.len - 5'd1);
  assign pop_o  = issue && is_end;
  assign idx_d  = is_end ? '0 : idx_q + 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= idx_d;
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      char_q <= head_i.ok ? head_i.chars[idx_q] : 8'h00;
      ok_q   <= head_i.ok;
      last_q <= is_end;
    end
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign out_ok_o    = ok_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/pdf_date_to_iso8601.sv =====
// ----------------------------------------------------------------------------
// pdf_date_to_iso8601
// converts a pdf date string into iso-8601 text
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one byte of the date string per request, tlast on the
//   final byte; one byte is taken every cycle while the string queue has room
//   m_axis returns the iso text one character per request, tuser[0] high
//   when the string parsed and tlast on the final character; a bad string
//   gives a single request with tdata 0, tuser 0 and tlast 1
//   the finished string is written into the queue, then its first character
//   into the output register; then one per cycle while m_axis is ready
//   throughput: one input byte per cycle, set by the parser; strings that
//   arrive faster than their runs drain are held in a QUEUE_DEPTH deep queue,
//   and s_axis_tready drops while that queue is full
//   reset clears parser, queue and output register; no clearing pass
//   a stall on m_axis holds the current character and lets bytes keep
//   arriving until the queue fills
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_date_to_iso8601 #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [0:0]      m_axis_tuser,   // [0] out_ok
  output logic            m_axis_tlast
);
  import pd2iso_pkg::*;

  frame_t    frame_in, head;
  q_status_t q_status;
  logic      push, pop;
  logic      out_ok;

  pd2iso_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_status_i (q_status),
    .push_o     (push),
    .frame_o    (frame_in)
  );

  pd2iso_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .frame_i  (frame_in),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  pd2iso_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_ok_o    (out_ok),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_ok;

`include "pdf_date_to_iso8601_macros.svh"

  `PD2ISO_ASSERT_NOW(a_bad_single, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == 8'h00), "failed string not a single zero request")
  `PD2ISO_ASSERT_NOW(a_no_push_full, push, !q_status.full, "string pushed into full queue")
  `PD2ISO_ASSERT_NEXT(a_push_lands, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_status.empty, "finished string missing from queue")
  `PD2ISO_ASSERT_NOW(a_pop_nonempty, pop, !q_status.empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== dv/tb_pdf_date_to_iso8601.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pdf_date_to_iso8601
// drives pdf date strings byte by byte into the converter and checks every
// iso-8601 character it returns against a table row's expected text or a
// running model of the parser; a short table of hand-picked strings comes
// first, then random strings, most of them well formed, with random gaps and
// stalls on both streams
`default_nettype none

module tb_pdf_date_to_iso8601;
  import pd2iso_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BYTES  = 120;
  localparam int unsigned DIR_N       = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       ok;
    logic       last;
  } iso_char_t;

  typedef struct {
    string pdf;
    bit    tab;
    string iso;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic       m_axis_tlast;

  pdf_date_to_iso8601 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dir_row_t    dir_rows [DIR_N];
  iso_char_t   iso_q [$];
  int unsigned err_cnt = 0;
  int unsigned cyc = 0;
  int          cur_row = -1;
  bit          calm = 1'b0;
  int unsigned rdy_left = 0;

  // parser model state
  logic [4:0]  mp_pos;
  tz_e         mp_tz;
  bit          mp_err;
  logic [7:0]  mp_buf [ISO_MAX];
  logic [4:0]  mp_len;
  logic [4:0]  slot_of [16] = '{5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6,
                                5'd8, 5'd9, 5'd11, 5'd12, 5'd14, 5'd15, 5'd17, 5'd18};

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp);
    $display("mismatch at cycle %0d: %s got %02h expected %02h", cyc, what, got, exp);
    err_cnt++;
  endtask

  task automatic clear_parser();
    mp_pos = '0;
    mp_tz  = TZ_NONE;
    mp_err = 1'b0;
    mp_len = '0;
    for (int i = 0; i < ISO_MAX; i++) mp_buf[i] = 8'h00;
  endtask

  function automatic bit is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // one grammar step at the current position
  task automatic take_byte(input logic [7:0] c, output bit ok);
    logic [4:0] p;
    logic [7:0] sep;
    p = mp_pos;
    ok = 1'b0;
    if (p >= POS_LIMIT) begin
      ok = 1'b0;
    end else if (p == POS_PREFIX) begin
      ok = (c == CH_D);
    end else if (p == POS_COLON) begin
      ok = (c == CH_COLON);
    end else if (p <= POS_DIG_END) begin
      if (is_dig(c)) begin
        if (p >= 6 && !p[0]) begin
          sep = (p == 10) ? CH_T : ((p >= 12) ? CH_COLON : CH_MINUS);
          mp_buf[slot_of[p[3:0]] - 1] = sep;
        end
        mp_buf[slot_of[p[3:0]]] = c;
        if (p >= 5 && p[0]) mp_len = slot_of[p[3:0]] + 5'd1;
        ok = 1'b1;
      end
    end else if (p == POS_TZ) begin
      if (c == CH_Z) begin
        mp_buf[19] = c;
        mp_tz = TZ_ZULU;
        mp_len = 5'd20;
        ok = 1'b1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        mp_buf[19] = c;
        mp_tz = TZ_OFFSET;
        ok = 1'b1;
      end
    end else if (mp_tz == TZ_OFFSET) begin
      case (p)
        POS_OFS_H0: if (is_dig(c)) begin mp_buf[20] = c; ok = 1'b1; end
        POS_OFS_H1: if (is_dig(c)) begin mp_buf[21] = c; ok = 1'b1; end
        POS_OFS_Q0: if (c == CH_QUOTE) begin mp_len = 5'd22; ok = 1'b1; end
        POS_OFS_M0: if (is_dig(c)) begin mp_buf[22] = c; ok = 1'b1; end
        POS_OFS_M1: if (is_dig(c)) begin mp_buf[23] = c; ok = 1'b1; end
        POS_OFS_Q1: if (c == CH_QUOTE) begin mp_len = 5'd24; ok = 1'b1; end
        default: ok = 1'b0;
      endcase
    end
  endtask

  // advance the model by one byte and queue what the final byte releases
  task automatic absorb_byte(input logic [7:0] c, input bit l, input bit push);
    bit ok;
    bit bnd;
    if (!mp_err) begin
      take_byte(c, ok);
      if (ok) mp_pos = mp_pos + 5'd1;
      else mp_err = 1'b1;
    end
    if (l) begin
      bnd = (mp_pos >= 6 && mp_pos <= 16 && !mp_pos[0]) ||
            (mp_pos == 17 && mp_tz == TZ_ZULU) ||
            ((mp_pos == 20 || mp_pos == 23) && mp_tz == TZ_OFFSET);
      if (push) begin
        if (mp_err || !bnd || mp_len == 0 || mp_len > ISO_MAX) begin
          iso_q.push_back('{ch: 8'h00, ok: 1'b0, last: 1'b1});
        end else begin
          for (int k = 0; k < mp_len; k++)
            iso_q.push_back('{ch: mp_buf[k], ok: 1'b1, last: (k == mp_len - 1)});
        end
      end
      clear_parser();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] c, input bit l, input int row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    cur_row       <= row;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_dig();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // model update on every accepted request
  always @(posedge clk_i) begin : in_mon
    bit use_tab;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      use_tab = s_axis_tlast && cur_row >= 0 && dir_rows[cur_row].tab;
      absorb_byte(s_axis_tdata, s_axis_tlast, !use_tab);
      if (use_tab) begin
        if (dir_rows[cur_row].iso.len() == 0) begin
          iso_q.push_back('{ch: 8'h00, ok: 1'b0, last: 1'b1});
        end else begin
          for (int k = 0; k < dir_rows[cur_row].iso.len(); k++)
            iso_q.push_back('{ch: dir_rows[cur_row].iso.getc(k), ok: 1'b1,
                              last: (k == dir_rows[cur_row].iso.len() - 1)});
        end
      end
    end
  end

  always @(posedge clk_i) begin : out_chk
    iso_char_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (iso_q.size() == 0) begin
        report_mismatch("unexpected result, char", m_axis_tdata, 8'h00);
      end else begin
        e = iso_q.pop_front();
        if (m_axis_tdata !== e.ch) report_mismatch("char", m_axis_tdata, e.ch);
        if (m_axis_tuser[0] !== e.ok)
          report_mismatch("valid flag", {7'd0, m_axis_tuser[0]}, {7'd0, e.ok});
        if (m_axis_tlast !== e.last)
          report_mismatch("last flag", {7'd0, m_axis_tlast}, {7'd0, e.last});
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin : rdy_gen
    int r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_axis_tready <= 1'b1;
        rdy_left <= $urandom_range(0, 6);
      end else if (r < 92) begin
        m_axis_tready <= 1'b0;
        rdy_left <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        rdy_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stim
    logic [7:0]  str [$];
    int unsigned sent;
    int          kind;
    int          groups;
    dir_rows = '{
      '{"D:99991231235959+23'59'", 1'b1, "9999-12-31T23:59:59+2359"},
      '{"D:00000101000000Z",       1'b1, "0000-01-01T00:00:00Z"},
      '{"D:2024",                  1'b1, "2024"},
      '{"D:202407",                1'b1, "2024-07"},
      '{"D:20240715083000-05'",    1'b0, ""},
      '{"D:2024071508",            1'b0, ""},
      '{"D:1999123",               1'b1, ""},
      '{"d:2024",                  1'b1, ""},
      '{"D:2024071508300",         1'b1, ""},
      '{"D:20240715083000+05'30'X", 1'b1, ""},
      '{"D:20240715083000Z0",      1'b1, ""},
      '{"D:20240715083000+0530",   1'b1, ""},
      '{"D:20240715083000+",       1'b1, ""},
      '{"D",                       1'b1, ""},
      '{"\377",                    1'b1, ""},
      '{"D:2024X\200",             1'b1, ""}
    };
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      for (int i = 0; i < dir_rows[r].pdf.len(); i++)
        send_byte(dir_rows[r].pdf.getc(i), i == dir_rows[r].pdf.len() - 1, r);
    end

    sent = 0;
    while (sent < RAND_BYTES) begin
      str.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise, up to 28 bytes
        repeat ($urandom_range(1, 28)) str.push_back(8'($urandom_range(0, 255)));
      end else begin
        groups = $urandom_range(0, 8);
        str.push_back(CH_D);
        str.push_back(CH_COLON);
        repeat (4) str.push_back(rand_dig());
        for (int g = 1; g <= groups && g <= 5; g++) repeat (2) str.push_back(rand_dig());
        if (groups == 6) begin
          str.push_back(CH_Z);
        end else if (groups >= 7) begin
          str.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          repeat (2) str.push_back(rand_dig());
          str.push_back(CH_QUOTE);
          if (groups == 8) begin
            repeat (2) str.push_back(rand_dig());
            str.push_back(CH_QUOTE);
          end
        end
        if (kind <= 3) begin
          // broken string
          case ($urandom_range(0, 3))
            0: str[$urandom_range(0, str.size() - 1)] = 8'($urandom_range(0, 255));
            1: void'(str.pop_back());
            2: str.push_back(8'($urandom_range(0, 255)));
            default: str.push_back(rand_dig());
          endcase
        end
      end
      calm <= ($urandom_range(0, 7) == 0);
      for (int i = 0; i < str.size(); i++) send_byte(str[i], i == str.size() - 1, -1);
      sent += str.size();
    end
    s_axis_tvalid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk_i);

    while (iso_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
